>>> design/tcps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types, register indexes and constants of the text cell pixel shader.
// ----------------------------------------------------------------------------
package tcps_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_REVERSE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_VISIBLE = 2'd3;

    localparam logic [3:0] FONT_WIDTH_RST  = 4'd8;
    localparam logic [5:0] FONT_HEIGHT_RST = 6'd16;

    localparam int ATTR_ITALIC    = 0;
    localparam int ATTR_BOLD      = 1;
    localparam int ATTR_DIM       = 2;
    localparam int ATTR_REVERSE   = 3;
    localparam int ATTR_UNDERLINE = 4;
    localparam int ATTR_DBL_ULINE = 5;
    localparam int ATTR_STRIKE    = 6;

    // pixel levels in twelfths
    localparam logic [3:0] LVL_FULL     = 4'd12;
    localparam logic [3:0] LVL_DIM_HI   = 4'd8;
    localparam logic [3:0] LVL_DIM_LO   = 4'd4;
    localparam logic [3:0] LVL_BOLD     = 4'd3;
    localparam logic [3:0] LVL_OFF      = 4'd0;

    localparam logic [23:0] LINE_XOR   = 24'h606060;
    localparam logic [6:0]  W_MAX      = 7'd127;
    localparam logic [5:0]  ROUND_HALF = 6'd48;
    // floor(y/3) == (y*683)>>11 for y below 384
    localparam logic [9:0]  RECIP3     = 10'd683;
    localparam int          RECIP3_SH  = 11;

    typedef logic [23:0] t_rgb;

    typedef struct packed {
        logic [3:0] font_width;
        logic [5:0] font_height;
        logic       screen_reverse;
        logic       cursor_visible;
    } t_cfg;

    typedef struct packed {
        logic [3:0] mask;
        logic [2:0] phase;
        logic       bold;
        logic       dim;
        logic       line;
        logic       swap;
        t_rgb       fg;
        t_rgb       bg;
    } t_cell;

    typedef struct packed {
        logic [6:0] w;
        t_rgb       fg;
        t_rgb       bg;
    } t_blend;

    function automatic logic [3:0] level12(input logic dim, input logic bold,
                                           input logic prv, input logic cur,
                                           input logic nxt);
        logic [3:0] lv;
        if (cur) begin
            if (dim && !nxt) begin
                lv = prv ? LVL_DIM_LO : LVL_DIM_HI;
            end else begin
                lv = LVL_FULL;
            end
        end else begin
            lv = (bold && prv) ? LVL_BOLD : LVL_OFF;
        end
        return lv;
    endfunction

endpackage
`default_nettype wire

>>> design/tcps_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_cfg
// Configuration register file, written through a valid/ready request port.
// ----------------------------------------------------------------------------
module tcps_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tcps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tcps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tcps_pkg::t_cfg                        o_cfg
);
    import tcps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FONT_WIDTH:     n_cfg.font_width     = i_cfg_data[3:0];
                CFG_FONT_HEIGHT:    n_cfg.font_height    = i_cfg_data[5:0];
                CFG_SCREEN_REVERSE: n_cfg.screen_reverse = i_cfg_data[0];
                CFG_CURSOR_VISIBLE: n_cfg.cursor_visible = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.font_width     <= FONT_WIDTH_RST;
            r_cfg.font_height    <= FONT_HEIGHT_RST;
            r_cfg.screen_reverse <= 1'b0;
            r_cfg.cursor_visible <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

>>> design/tcps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_front
// Stage 1: glyph neighbourhood, slant phase, line rows and colour swap.
// ----------------------------------------------------------------------------
module tcps_front #(
    parameter int MAX_FONT_HEIGHT = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_glyph_row,
    input  wire logic [2:0]     i_pixel_column,
    input  wire logic [4:0]     i_font_row,
    input  wire logic [23:0]    i_fg_color,
    input  wire logic [23:0]    i_bg_color,
    input  wire logic [6:0]     i_attr_flags,
    input  wire logic           i_at_cursor,
    input  tcps_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output tcps_pkg::t_cell     o_cell
);
    import tcps_pkg::*;

    localparam int FY_W = $clog2(MAX_FONT_HEIGHT + 1);
    localparam int HW   = (FY_W > 6) ? FY_W : 6;
    localparam int PW   = (FY_W + 3 > 8) ? FY_W + 3 : 8;
    localparam int LW   = (FY_W > 5) ? FY_W : 5;

    logic          r_valid;
    t_cell         r_cell;
    t_cell         n_cell;
    logic [HW-1:0] fh;
    logic [FY_W-1:0] fy;
    logic [PW-1:0] row8;
    logic [2:0]    cnt;
    logic [LW-1:0] row_l;
    logic [LW-1:0] fy_l;
    logic [8:0]    wide;
    logic [10:0]   win;
    logic [3:0]    shift;
    logic          italic;

    always_comb begin
        italic = i_attr_flags[ATTR_ITALIC];
        fh     = HW'(i_cfg.font_height);
        if (fh == '0) begin
            fy = FY_W'(1);
        end else if (fh > HW'(MAX_FONT_HEIGHT)) begin
            fy = FY_W'(MAX_FONT_HEIGHT);
        end else begin
            fy = FY_W'(fh);
        end

        // row*8/fy saturated at 7, as a count of crossed thresholds
        row8 = PW'({i_font_row, 3'b000});
        cnt  = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (row8 >= PW'(fy) * PW'(k)) begin
                cnt = cnt + 3'd1;
            end
        end

        row_l = LW'(i_font_row);
        fy_l  = LW'(fy);

        wide  = italic ? {1'b0, i_glyph_row} : {i_glyph_row, 1'b0};
        win   = {wide, 2'b00};
        shift = (i_cfg.font_width > {1'b0, i_pixel_column})
              ? i_cfg.font_width - {1'b0, i_pixel_column} : 4'd0;

        n_cell.mask  = 4'(win >> shift);
        n_cell.phase = italic ? cnt : 3'd0;
        n_cell.bold  = i_attr_flags[ATTR_BOLD];
        n_cell.dim   = i_attr_flags[ATTR_DIM];
        n_cell.line  = (i_attr_flags[ATTR_UNDERLINE] && row_l == fy_l - LW'(1))
                    || (i_attr_flags[ATTR_DBL_ULINE]
                        && (row_l == fy_l - LW'(1)
                            || (fy_l >= LW'(3) && row_l == fy_l - LW'(3))))
                    || (i_attr_flags[ATTR_STRIKE] && row_l == (fy_l >> 1));
        n_cell.swap  = i_attr_flags[ATTR_REVERSE]
                     ^ (i_at_cursor & i_cfg.cursor_visible)
                     ^ i_cfg.screen_reverse;
        n_cell.fg    = i_fg_color;
        n_cell.bg    = i_bg_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule
`default_nettype wire

>>> design/tcps_weight.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_weight
// Stages 2 to 4: slanted intensity in 96ths, rounding to a 7-bit weight,
// colour swap and line XOR carried alongside.
// ----------------------------------------------------------------------------
module tcps_weight (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  tcps_pkg::t_cell  i_cell,
    output logic             o_valid,
    output tcps_pkg::t_blend o_blend
);
    import tcps_pkg::*;

    logic [2:0]  r_valid;
    logic [6:0]  r_f96;
    logic [8:0]  r_y;
    logic [6:0]  r_w;
    t_rgb        r_fg2, r_bg2, r_fg3, r_bg3, r_fg4, r_bg4;

    logic [3:0]  lv_t, lv_n;
    logic [3:0]  p_inv;
    logic [7:0]  n_f96;
    logic [13:0] x;
    logic [8:0]  n_y;
    logic [18:0] prod;
    logic [6:0]  n_w;
    t_rgb        n_fg, n_bg;

    always_comb begin
        lv_t  = level12(i_cell.dim, i_cell.bold, i_cell.mask[3], i_cell.mask[2],
                        i_cell.mask[1]);
        lv_n  = level12(i_cell.dim, i_cell.bold, i_cell.mask[2], i_cell.mask[1],
                        i_cell.mask[0]);
        p_inv = 4'd8 - {1'b0, i_cell.phase};
        n_f96 = 8'(lv_t * p_inv) + 8'(lv_n * {1'b0, i_cell.phase});
        n_fg  = i_cell.swap ? i_cell.bg : i_cell.fg;
        n_bg  = (i_cell.swap ? i_cell.fg : i_cell.bg) ^ (i_cell.line ? LINE_XOR : '0);

        x     = {r_f96, 7'b0} - 14'(r_f96) + 14'(ROUND_HALF);
        n_y   = x[13:5];

        prod  = 19'(r_y) * 19'(RECIP3);
        n_w   = 7'(prod >> RECIP3_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f96 <= n_f96[6:0];
            r_fg2 <= n_fg;
            r_bg2 <= n_bg;
            r_y   <= n_y;
            r_fg3 <= r_fg2;
            r_bg3 <= r_bg2;
            r_w   <= n_w;
            r_fg4 <= r_fg3;
            r_bg4 <= r_bg3;
        end
    end

    assign o_valid    = r_valid[2];
    assign o_blend.w  = r_w;
    assign o_blend.fg = r_fg4;
    assign o_blend.bg = r_bg4;

endmodule
`default_nettype wire

>>> design/tcps_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_blend
// Stage 5: per-channel blend (bg*(127-w) + fg*w) / 128 into the output register.
// ----------------------------------------------------------------------------
module tcps_blend (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  tcps_pkg::t_blend  i_blend,
    output logic              o_valid,
    output logic [23:0]       o_pixel_color
);
    import tcps_pkg::*;

    logic        r_valid;
    t_rgb        r_pix;
    t_rgb        n_pix;
    logic [6:0]  w_inv;
    logic [14:0] acc;

    always_comb begin
        w_inv = W_MAX - i_blend.w;
        n_pix = '0;
        acc   = '0;
        for (int c = 0; c < 3; c++) begin
            acc = 15'(i_blend.bg[c*8 +: 8]) * 15'(w_inv)
                + 15'(i_blend.fg[c*8 +: 8]) * 15'(i_blend.w);
            n_pix[c*8 +: 8] = acc[14:7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_color = r_pix;

endmodule
`default_nettype wire

>>> design/text_cell_pixel_shader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_pixel_shader
// Pipeline stages from request to pixel: decode, intensity, rounding,
// reciprocal multiply, blend. Throughput: one pixel per clock while no output stall is held.
// A held output stall freezes all five stages; nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module text_cell_pixel_shader #(
    parameter int MAX_FONT_HEIGHT = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [7:0]                       i_glyph_row,
    input  wire logic [2:0]                       i_pixel_column,
    input  wire logic [4:0]                       i_font_row,
    input  wire logic [23:0]                      i_fg_color,
    input  wire logic [23:0]                      i_bg_color,
    input  wire logic [6:0]                       i_attr_flags,
    input  wire logic                             i_at_cursor,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [23:0]                           o_pixel_color,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tcps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tcps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tcps_pkg::*;

    t_cfg   w_cfg;
    t_cell  w_cell;
    t_blend w_blend;
    logic   w_v1;
    logic   w_v4;
    logic   w_en;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    tcps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tcps_front #(
        .MAX_FONT_HEIGHT (MAX_FONT_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_glyph_row    (i_glyph_row),
        .i_pixel_column (i_pixel_column),
        .i_font_row     (i_font_row),
        .i_fg_color     (i_fg_color),
        .i_bg_color     (i_bg_color),
        .i_attr_flags   (i_attr_flags),
        .i_at_cursor    (i_at_cursor),
        .i_cfg          (w_cfg),
        .o_valid        (w_v1),
        .o_cell         (w_cell)
    );

    tcps_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_cell  (w_cell),
        .o_valid (w_v4),
        .o_blend (w_blend)
    );

    tcps_blend u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_v4),
        .i_blend       (w_blend),
        .o_valid       (o_valid),
        .o_pixel_color (o_pixel_color)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall raised without a held output");

    a_request_enters_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_v1)
        else $error("accepted request missing from first stage");

    a_cfg_stable_without_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(w_cfg))
        else $error("configuration changed without a write");

endmodule
`default_nettype wire

>>> test/tb_text_cell_pixel_shader.sv
// ----------------------------------------------------------------------------
// tb_text_cell_pixel_shader
// Self-checking bench for the text cell pixel shader. Pixel requests go in
// through the valid/stall port, and an in-bench shading model predicts each
// blended colour. Results are compared in order. The four registers are
// swept over corner and random settings, with sender gaps and receiver
// back-pressure on and off.
// ----------------------------------------------------------------------------
module tb_text_cell_pixel_shader;
    import tcps_pkg::*;

    localparam int FONT_HEIGHT_CAP = 32;
    localparam int RUN_LIMIT       = 4_000_000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_glyph_row    = '0;
    logic [2:0]            i_pixel_column = '0;
    logic [4:0]            i_font_row     = '0;
    logic [23:0]           i_fg_color     = '0;
    logic [23:0]           i_bg_color     = '0;
    logic [6:0]            i_attr_flags   = '0;
    logic                  i_at_cursor    = 1'b0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [23:0]           o_pixel_color;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // register shadow, reset values
    logic [3:0] shadow_font_width     = 4'd8;
    logic [5:0] shadow_font_height    = 6'd16;
    logic       shadow_screen_reverse = 1'b0;
    logic       shadow_cursor_visible = 1'b1;

    t_rgb expected_pixels[$];
    int   sender_gap_pct   = 0;
    int   stall_pct        = 0;
    int   mismatch_count   = 0;
    int   pixels_checked   = 0;
    int   settings_applied = 0;

    text_cell_pixel_shader #(
        .MAX_FONT_HEIGHT(FONT_HEIGHT_CAP)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_glyph_row    (i_glyph_row),
        .i_pixel_column (i_pixel_column),
        .i_font_row     (i_font_row),
        .i_fg_color     (i_fg_color),
        .i_bg_color     (i_bg_color),
        .i_attr_flags   (i_attr_flags),
        .i_at_cursor    (i_at_cursor),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_color  (o_pixel_color),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end

    function automatic int clamped_height();
        int fy;
        fy = int'(shadow_font_height);
        if (fy < 1) begin
            fy = 1;
        end
        if (fy > FONT_HEIGHT_CAP) begin
            fy = FONT_HEIGHT_CAP;
        end
        return fy;
    endfunction

    // pixel level in twelfths from the lit state of a pixel and its neighbours
    function automatic int twelfths(input logic dim, input logic bold, input logic lit_prev,
                                    input logic lit, input logic lit_next);
        if (!lit) begin
            return (bold && lit_prev) ? 3 : 0;
        end
        if (dim && !lit_next) begin
            return lit_prev ? 4 : 8;
        end
        return 12;
    endfunction

    function automatic t_rgb shade_pixel(input logic [7:0] glyph, input logic [2:0] col,
                                         input logic [4:0] row, input t_rgb fg, input t_rgb bg,
                                         input logic [6:0] attr, input logic cursor);
        int         fy, ry, phase, wide, shift, lvl_a, lvl_b, w, ch;
        logic [3:0] nbr;
        logic       line, swap;
        t_rgb       ink, paper, pix;
        fy = clamped_height();
        ry = int'(row);
        phase = 0;
        if (attr[ATTR_ITALIC]) begin
            phase = (ry * 8) / fy;
            if (phase > 7) begin
                phase = 7;
            end
        end
        wide  = attr[ATTR_ITALIC] ? int'(glyph) : int'(glyph) << 1;
        shift = (int'(shadow_font_width) > int'(col)) ? shadow_font_width - col : 0;
        nbr   = 4'(((wide << 2) >> shift) & 15);
        lvl_a = twelfths(attr[ATTR_DIM], attr[ATTR_BOLD], nbr[3], nbr[2], nbr[1]);
        lvl_b = twelfths(attr[ATTR_DIM], attr[ATTR_BOLD], nbr[2], nbr[1], nbr[0]);
        // slant interpolation in 96ths, rounded half up to 7 bits
        w = ((lvl_a * 8 + (lvl_b - lvl_a) * phase) * 127 + 48) / 96;
        line = (attr[ATTR_UNDERLINE] && ry == fy - 1) ||
               (attr[ATTR_DBL_ULINE] && (ry == fy - 1 || ry == fy - 3)) ||
               (attr[ATTR_STRIKE] && ry == fy / 2);
        swap  = attr[ATTR_REVERSE] ^ (cursor & shadow_cursor_visible) ^ shadow_screen_reverse;
        ink   = swap ? bg : fg;
        paper = swap ? fg : bg;
        if (line) begin
            paper = paper ^ LINE_XOR;
        end
        for (int s = 0; s < 24; s += 8) begin
            ch = (int'(paper[s+:8]) * (127 - w) + int'(ink[s+:8]) * w) / 128;
            pix[s+:8] = ch[7:0];
        end
        return pix;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected pixel, expected none actual %06h",
                         $time, o_pixel_color);
            end else begin
                t_rgb want;
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (o_pixel_color !== want) begin
                    mismatch_count++;
                    $display("%0t: pixel_color mismatch, expected %06h actual %06h",
                             $time, want, o_pixel_color);
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] glyph, input logic [2:0] col,
                              input logic [4:0] row, input t_rgb fg, input t_rgb bg,
                              input logic [6:0] attr, input logic cursor);
        while (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_glyph_row    <= glyph;
        i_pixel_column <= col;
        i_font_row     <= row;
        i_fg_color     <= fg;
        i_bg_color     <= bg;
        i_attr_flags   <= attr;
        i_at_cursor    <= cursor;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_pixels.push_back(shade_pixel(glyph, col, row, fg, bg, attr, cursor));
    endtask

    task automatic drain_pixels();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // all four registers back to back; spare data bits carry noise
    task automatic apply_settings(input int fw, input int fh, input logic sr, input logic cv);
        logic [CFG_DATA_W-1:0] data [4];
        logic [CFG_IDX_W-1:0]  idx  [4];
        drain_pixels();
        idx[0]  = CFG_FONT_WIDTH;
        idx[1]  = CFG_FONT_HEIGHT;
        idx[2]  = CFG_SCREEN_REVERSE;
        idx[3]  = CFG_CURSOR_VISIBLE;
        data[0] = {2'($urandom_range(0, 3)), 4'(fw)};
        data[1] = 6'(fh);
        data[2] = {5'($urandom_range(0, 31)), sr};
        data[3] = {5'($urandom_range(0, 31)), cv};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= data[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid           <= 1'b0;
        shadow_font_width     = data[0][3:0];
        shadow_font_height    = data[1];
        shadow_screen_reverse = data[2][0];
        shadow_cursor_visible = data[3][0];
        settings_applied++;
    endtask

    task automatic test_reset_defaults();
        int rows [7];
        rows = '{12, 4, 4, 4, 15, 13, 8};
        send_pixel(8'h00, 3'd0, 5'd0, 24'hFFFFFF, 24'h000000, 7'h00, 1'b0);
        send_pixel(8'hFF, 3'd7, 5'd31, 24'hFFFFFF, 24'h000000, 7'h00, 1'b0);
        send_pixel(8'hA5, 3'd3, 5'd5, 24'hFFFFFF, 24'hFFFFFF, 7'h7F, 1'b1);
        // one attribute at a time, on a row where it takes effect
        for (int b = 0; b < 7; b++) begin
            send_pixel(8'h5A, 3'(b), 5'(rows[b]), 24'hFF8000, 24'h0080FF, 7'(1 << b), 1'b0);
        end
        send_pixel(8'h3C, 3'd2, 5'd4, 24'h123456, 24'hFEDCBA, 7'h00, 1'b1);
        // slant phase saturates past the cell height
        send_pixel(8'h81, 3'd0, 5'd31, 24'hFFFFFF, 24'h000000,
                   7'(1 << ATTR_ITALIC), 1'b0);
    endtask

    task automatic test_register_corners();
        // zero width and height: no shift, height clamps to one
        apply_settings(0, 0, 1'b1, 1'b0);
        send_pixel(8'hFF, 3'd0, 5'd0, 24'hFFFFFF, 24'h000000,
                   7'((1 << ATTR_ITALIC) | (1 << ATTR_UNDERLINE)), 1'b1);
        send_pixel(8'h80, 3'd7, 5'd1, 24'hC0FFEE, 24'h0A0B0C, 7'(1 << ATTR_STRIKE), 1'b0);
        send_pixel(8'h01, 3'd4, 5'd0, 24'h00FF00, 24'hFF00FF, 7'(1 << ATTR_DBL_ULINE), 1'b0);
        // widest register values, height above the cap
        apply_settings(15, 63, 1'b0, 1'b1);
        send_pixel(8'hFF, 3'd0, 5'd31, 24'hFFFFFF, 24'h000000,
                   7'((1 << ATTR_ITALIC) | (1 << ATTR_BOLD)), 1'b1);
        send_pixel(8'h81, 3'd7, 5'd31, 24'h808080, 24'h7F7F7F, 7'(1 << ATTR_UNDERLINE), 1'b0);
        send_pixel(8'h55, 3'd7, 5'd16, 24'h00FFFF, 24'hFF0000, 7'(1 << ATTR_STRIKE), 1'b0);
        // narrowest specified font
        apply_settings(4, 8, 1'b1, 1'b1);
        send_pixel(8'hF0, 3'd3, 5'd7, 24'hFFFFFF, 24'h202020,
                   7'((1 << ATTR_UNDERLINE) | (1 << ATTR_DIM)), 1'b0);
        send_pixel(8'h0F, 3'd0, 5'd5, 24'h112233, 24'h998877, 7'(1 << ATTR_DBL_ULINE), 1'b0);
        send_pixel(8'hAA, 3'd4, 5'd4, 24'hFFFFFF, 24'h000000,
                   7'((1 << ATTR_STRIKE) | (1 << ATTR_ITALIC)), 1'b1);
    endtask

    task automatic send_random_pixel();
        logic [7:0] glyph;
        logic [4:0] row;
        t_rgb       fg, bg;
        int         fy, target;
        glyph = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 15))
            0: glyph = 8'h00;
            1: glyph = 8'hFF;
            default: ;
        endcase
        fy  = clamped_height();
        row = 5'($urandom_range(0, 31));
        // aim a quarter of the requests at the line rows
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: target = fy - 1;
                1: target = fy - 3;
                default: target = fy / 2;
            endcase
            if (target >= 0 && target <= 31) begin
                row = 5'(target);
            end
        end
        fg = 24'($urandom);
        bg = 24'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            fg = 24'hFFFFFF;
            bg = 24'h000000;
        end
        send_pixel(glyph, 3'($urandom_range(0, 7)), row, fg, bg,
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_traffic(input int gap_pct, input int bp_pct);
        int fw, fh;
        sender_gap_pct = gap_pct;
        stall_pct      = bp_pct;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: apply_settings(8, 16, 1'b0, 1'b1);
                1: apply_settings(4, 8, 1'b1, 1'b0);
                2: apply_settings(8, 32, 1'b0, 1'b0);
                default: begin
                    fw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(4, 8);
                    fh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(8, 32);
                    apply_settings(fw, fh, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                end
            endcase
            repeat (95) send_random_pixel();
        end
    endtask

    initial begin
        sender_gap_pct = 8;
        stall_pct      = 54;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_corners();
        test_random_traffic(8, 54);
        test_random_traffic(54, 8);
        test_random_traffic(0, 0);
        drain_pixels();
        $display("Checked %0d pixels over %0d register settings,", pixels_checked,
                 settings_applied);
        $display("with and without sender gaps and output back-pressure.");
        if (mismatch_count == 0) begin
            $display("** text_cell_pixel_shader: PASSED **");
        end else begin
            $display("** text_cell_pixel_shader: FAILED **");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("%0t: timeout, %0d pixels still expected", $time, expected_pixels.size());
        $display("** text_cell_pixel_shader: FAILED **");
        $finish;
    end

endmodule

>>> text_cell_pixel_shader.f
design/tcps_pkg.sv
design/tcps_cfg.sv
design/tcps_front.sv
design/tcps_weight.sv
design/tcps_blend.sv
design/text_cell_pixel_shader.sv
test/tb_text_cell_pixel_shader.sv
